### hdl/sal_pkg.sv
// Shared types and constants for the skyline atlas allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sal_pkg;

    // Atlas edge length in texels, widths derived from it, and the port field width
    localparam int ATLAS_SIZE = 128;
    localparam int IDX_W      = $clog2(ATLAS_SIZE);
    localparam int HGT_W      = $clog2(ATLAS_SIZE + 1);
    localparam int FIELD_W    = 7;

    // Request codes
    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_SAVE    = 2'd1,
        REQ_RESTORE = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WIN,
        ST_SCAN,
        ST_PLACE,
        ST_COPY,
        ST_DONE
    } t_state;

    // Broadcast commands from the sequencer to every column cell
    typedef struct packed {
        logic             load;      // s <= height, m <= 0
        logic             win;       // m <= max(m, s), s shifts toward column 0
        logic             scan;      // m shifts toward column 0
        logic             raise;     // write raise_val over [spot, end_col)
        logic             save;
        logic             restore;
        logic             clear;
        logic [HGT_W-1:0] raise_val;
        logic [IDX_W-1:0] spot;
        logic [IDX_W:0]   end_col;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/sal_cell.sv
// One skyline column: fill height, snapshot, and the shift/window-max registers.
// Depends on sal_pkg; chained by the top level, column 0 at the head.
`default_nettype none

module sal_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [sal_pkg::IDX_W-1:0] i_idx,
    input  wire sal_pkg::t_cell_ctl      i_ctl,
    input  wire logic [sal_pkg::HGT_W-1:0] i_s_next,
    input  wire logic [sal_pkg::HGT_W-1:0] i_m_next,
    output logic      [sal_pkg::HGT_W-1:0] o_s,
    output logic      [sal_pkg::HGT_W-1:0] o_m
);
    import sal_pkg::*;

    logic [HGT_W-1:0] r_hgt;
    logic [HGT_W-1:0] r_saved;
    logic [HGT_W-1:0] r_s;
    logic [HGT_W-1:0] r_m;
    logic             in_range;

    // column covered by the rectangle being placed
    assign in_range = (i_idx >= i_ctl.spot) && ({1'b0, i_idx} < i_ctl.end_col);

    // skyline height and snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hgt   <= '0;
            r_saved <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_hgt <= '0;
            end else if (i_ctl.restore) begin
                r_hgt <= r_saved;
            end else if (i_ctl.raise && in_range) begin
                r_hgt <= i_ctl.raise_val;
            end
            if (i_ctl.save) begin
                r_saved <= r_hgt;
            end
        end
    end

    // window maximum: heights slide past, max accumulates; then maxima shift out
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s <= r_hgt;
            r_m <= '0;
        end else if (i_ctl.win) begin
            r_s <= i_s_next;
            r_m <= (r_s > r_m) ? r_s : r_m;
        end else if (i_ctl.scan) begin
            r_m <= i_m_next;
        end
    end

    assign o_s = r_s;
    assign o_m = r_m;

endmodule

`default_nettype wire

### hdl/sal_ctrl.sv
// Sequencer: takes requests, drives the column cells, picks the lowest spot
// from the maxima streaming out of column 0, and holds the result.
// Depends on sal_pkg.
`default_nettype none

module sal_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic [sal_pkg::FIELD_W-1:0] i_rect_width,
    input  wire logic [sal_pkg::FIELD_W-1:0] i_rect_height,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_fits,
    output logic      [sal_pkg::FIELD_W-1:0] o_place_col,
    output logic      [sal_pkg::FIELD_W-1:0] o_place_row,
    input  wire logic [sal_pkg::HGT_W-1:0]   i_head_m,
    output sal_pkg::t_cell_ctl               o_ctl
);
    import sal_pkg::*;

    t_state           r_state, n_state;
    t_req             r_req;
    logic [HGT_W-1:0] r_w;
    logic [HGT_W-1:0] r_h;
    logic [HGT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [HGT_W-1:0] r_best;
    logic [IDX_W-1:0] r_spot;
    logic             r_res_fits;
    logic [IDX_W-1:0] r_res_col;
    logic [HGT_W-1:0] r_res_row;
    logic             r_out_valid;
    logic             r_fits;
    logic [FIELD_W-1:0] r_col;
    logic [FIELD_W-1:0] r_row;

    logic             accept;
    logic             win_last;
    logic             scan_last;
    logic             cand_ok;
    logic             fit_ok;
    logic [HGT_W:0]   top_sum;
    logic             out_free;

    assign accept    = i_valid && o_ready;
    assign win_last  = (r_cnt == HGT_W'(1));
    assign scan_last = (r_idx == IDX_W'(ATLAS_SIZE - 1));
    // start column is legal while it plus the bordered width is less than the atlas width
    assign cand_ok   = ((HGT_W+1)'(r_idx) + (HGT_W+1)'(r_w)) < (HGT_W+1)'(ATLAS_SIZE);
    assign top_sum   = (HGT_W+1)'(r_best) + (HGT_W+1)'(r_h);
    assign fit_ok    = top_sum <= (HGT_W+1)'(ATLAS_SIZE);
    assign out_free  = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (t_req'(i_req_type) == REQ_ALLOC) ? ST_LOAD : ST_COPY;
                end
            end
            ST_LOAD:  n_state = ST_WIN;
            ST_WIN:   if (win_last) n_state = ST_SCAN;
            ST_SCAN:  if (scan_last) n_state = ST_PLACE;
            ST_PLACE: n_state = ST_DONE;
            ST_COPY:  n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // cell commands and input ready
    always_comb begin
        o_ready           = (r_state == ST_IDLE);
        o_ctl             = '0;
        o_ctl.raise_val   = HGT_W'(top_sum);
        o_ctl.spot        = r_spot;
        o_ctl.end_col     = (IDX_W+1)'((HGT_W+1)'(r_spot) + (HGT_W+1)'(r_w));
        unique case (r_state)
            ST_LOAD:  o_ctl.load  = 1'b1;
            ST_WIN:   o_ctl.win   = 1'b1;
            ST_SCAN:  o_ctl.scan  = 1'b1;
            ST_PLACE: o_ctl.raise = fit_ok;
            ST_COPY: begin
                o_ctl.save    = (r_req == REQ_SAVE);
                o_ctl.restore = (r_req == REQ_RESTORE);
                o_ctl.clear   = (r_req == REQ_CLEAR);
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture, counters, lowest-spot search, result staging
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(i_req_type);
            r_w   <= HGT_W'(i_rect_width) + HGT_W'(1);
            r_h   <= HGT_W'(i_rect_height) + HGT_W'(1);
            r_cnt <= HGT_W'(i_rect_width) + HGT_W'(1);
        end
        if (r_state == ST_LOAD) begin
            r_idx  <= '0;
            r_best <= HGT_W'(ATLAS_SIZE);
            r_spot <= '0;
        end
        if (r_state == ST_WIN) begin
            r_cnt <= r_cnt - HGT_W'(1);
        end
        if (r_state == ST_SCAN) begin
            r_idx <= r_idx + IDX_W'(1);
            if (cand_ok && (i_head_m < r_best)) begin
                r_best <= i_head_m;
                r_spot <= r_idx;
            end
        end
        if (r_state == ST_PLACE) begin
            r_res_fits <= fit_ok;
            r_res_col  <= fit_ok ? r_spot : '0;
            r_res_row  <= fit_ok ? r_best : '0;
        end
        if (r_state == ST_COPY) begin
            r_res_fits <= 1'b1;
            r_res_col  <= '0;
            r_res_row  <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_fits <= r_res_fits;
            r_col  <= FIELD_W'(r_res_col);
            r_row  <= FIELD_W'(r_res_row);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_fits      = r_fits;
    assign o_place_col = r_col;
    assign o_place_row = r_row;

endmodule

`default_nettype wire

### hdl/skyline_atlas_allocator.sv
// Allocate: load of the window registers, the window-max slide over w columns
// (w = width + 1), the scan out of column 0, then the placement step and the result.
// Save, restore, clear: the copy step, then the result. A new request is taken
// only after the result moves to the output register, one request at a time.
// Synchronous active-low reset zeroes the skyline and the snapshot and leaves
// no result pending.
`default_nettype none

module skyline_atlas_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic [sal_pkg::FIELD_W-1:0] i_rect_width,
    input  wire logic [sal_pkg::FIELD_W-1:0] i_rect_height,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_fits,
    output logic      [sal_pkg::FIELD_W-1:0] o_place_col,
    output logic      [sal_pkg::FIELD_W-1:0] o_place_row
);
    import sal_pkg::*;

    t_cell_ctl        ctl;
    logic [HGT_W-1:0] s_chain [ATLAS_SIZE+1];
    logic [HGT_W-1:0] m_chain [ATLAS_SIZE+1];

    // zeros enter past the last column
    assign s_chain[ATLAS_SIZE] = '0;
    assign m_chain[ATLAS_SIZE] = '0;

    sal_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_fits        (o_fits),
        .o_place_col   (o_place_col),
        .o_place_row   (o_place_row),
        .i_head_m      (m_chain[0]),
        .o_ctl         (ctl)
    );

    // row of column cells, each fed by its right-hand neighbor, the last one by zeros
    for (genvar gi = 0; gi < ATLAS_SIZE; gi++) begin : g_col
        sal_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(gi)),
            .i_ctl    (ctl),
            .i_s_next (s_chain[gi+1]),
            .i_m_next (m_chain[gi+1]),
            .o_s      (s_chain[gi]),
            .o_m      (m_chain[gi])
        );
    end

endmodule

`default_nettype wire

### bench/skyline_atlas_allocator_test.sv
// Self-checking bench for the skyline atlas allocator: directed and random requests,
// with results checked against a behavioral skyline model kept in the bench.
// Depends on sal_pkg and skyline_atlas_allocator from hdl/.
`timescale 1ns / 1ps

module skyline_atlas_allocator_test;
    import sal_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 1000;

    typedef struct {
        logic                fits;
        logic [FIELD_W-1:0]  col;
        logic [FIELD_W-1:0]  row;
    } t_placement;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_req_type = REQ_ALLOC;
    logic [FIELD_W-1:0]  i_rect_width = '0;
    logic [FIELD_W-1:0]  i_rect_height = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_fits;
    logic [FIELD_W-1:0]  o_place_col;
    logic [FIELD_W-1:0]  o_place_row;

    // Bench copy of the skyline and its snapshot
    logic [HGT_W-1:0]    col_height [ATLAS_SIZE] = '{default: '0};
    logic [HGT_W-1:0]    saved_height [ATLAS_SIZE] = '{default: '0};

    t_placement          placement_q [$];
    int                  fail_count = 0;
    int                  cycle_count = 0;
    bit                  last_fits;

    // Sender burst control
    bit                  sender_idle_en = 1'b1;
    int                  burst_left = 0;

    // Receiver stall control
    int                  hold_req = 0;
    int                  hold_left = 0;
    int                  pat_cnt = 0;
    int                  ready_mode = 0;
    logic [15:0]         stall_pat = 16'hA5C3;

    skyline_atlas_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_fits        (o_fits),
        .o_place_col   (o_place_col),
        .o_place_row   (o_place_row)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[skyline_atlas_allocator] ERROR");
            $finish;
        end
    end

    // Skyline placement: first start column with the strictly lowest window max
    function automatic t_placement predict_placement(t_req req, logic [FIELD_W-1:0] wf,
                                                     logic [FIELD_W-1:0] hf);
        t_placement res;
        int bw;
        int bh;
        int best;
        int spot;
        int top;
        res = '{fits: 1'b1, col: '0, row: '0};
        bw = int'(wf) + 1;
        bh = int'(hf) + 1;
        case (req)
            REQ_ALLOC: begin
                best = ATLAS_SIZE;
                spot = 0;
                // last column is never a start position
                for (int s = 0; s < ATLAS_SIZE - bw; s++) begin
                    top = 0;
                    for (int k = 0; k < bw; k++)
                        if (int'(col_height[s + k]) > top) top = col_height[s + k];
                    if (top < best) begin
                        best = top;
                        spot = s;
                    end
                end
                if (best + bh > ATLAS_SIZE) begin
                    res.fits = 1'b0;
                end else begin
                    for (int k = 0; k < bw; k++) col_height[spot + k] = HGT_W'(best + bh);
                    res.col = FIELD_W'(spot);
                    res.row = FIELD_W'(best);
                end
            end
            REQ_SAVE:    saved_height = col_height;
            REQ_RESTORE: col_height = saved_height;
            default:     col_height = '{default: '0};
        endcase
        return res;
    endfunction

    // Offer one request, wait for the transfer, then record the expected result
    task automatic send_request(t_req req, int w, int h);
        int gap;
        t_placement exp_res;
        if (sender_idle_en) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
                                                  : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 8);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_rect_width  <= FIELD_W'(w);
        i_rect_height <= FIELD_W'(h);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        exp_res = predict_placement(req, FIELD_W'(w), FIELD_W'(h));
        last_fits = exp_res.fits;
        placement_q.push_back(exp_res);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_placement exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (placement_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                exp_res = placement_q.pop_front();
                if (o_fits !== exp_res.fits) begin
                    $error("fits: expected %0d, actual %0d", exp_res.fits, o_fits);
                    fail_count++;
                end
                if (o_place_col !== exp_res.col) begin
                    $error("place_col: expected %0d, actual %0d", exp_res.col, o_place_col);
                    fail_count++;
                end
                if (o_place_row !== exp_res.row) begin
                    $error("place_row: expected %0d, actual %0d", exp_res.row, o_place_row);
                    fail_count++;
                end
            end
        end
    end

    // Receiver ready: hold-off on request, else always ready, patterned or random stalls
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            pat_cnt++;
            if (pat_cnt % 256 == 0) begin
                ready_mode = $urandom_range(0, 2);
                stall_pat  = 16'($urandom) | 16'h0001;
            end
            case (ready_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= stall_pat[pat_cnt % 16];
                default: i_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Extremes, too-wide, full-height, last-column and snapshot cases
    task automatic test_directed_edges();
        send_request(REQ_CLEAR, 0, 0);
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 127, 0);      // bordered width = atlas width
        send_request(REQ_ALLOC, 127, 127);
        send_request(REQ_CLEAR, 127, 127);
        send_request(REQ_ALLOC, 126, 127);    // one start column, full height
        send_request(REQ_ALLOC, 0, 0);        // only the unused last column is free
        send_request(REQ_SAVE, 85, 42);
        send_request(REQ_CLEAR, 0, 0);
        send_request(REQ_ALLOC, 5, 3);
        send_request(REQ_RESTORE, 42, 85);
        send_request(REQ_ALLOC, 0, 0);
    endtask

    // Fill with identical squares until no room is left
    task automatic test_fill_until_full();
        int n;
        n = 0;
        send_request(REQ_CLEAR, 0, 0);
        do begin
            send_request(REQ_ALLOC, 31, 31);
            n++;
        end while (last_fits && n < 16);
    endtask

    // Random mix, mostly allocations of varied sizes
    task automatic test_random_mix();
        int r;
        int w;
        int h;
        t_req req;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) sender_idle_en = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 84)      req = REQ_ALLOC;
            else if (r < 90) req = REQ_SAVE;
            else if (r < 96) req = REQ_RESTORE;
            else             req = REQ_CLEAR;
            r = $urandom_range(0, 99);
            if (r < 50) begin
                w = $urandom_range(0, 15);
                h = $urandom_range(0, 15);
            end else if (r < 88) begin
                w = $urandom_range(16, 63);
                h = $urandom_range(0, 63);
            end else begin
                w = $urandom_range(0, 127);
                h = $urandom_range(0, 127);
            end
            send_request(req, w, h);
        end
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_output_backpressure();
        sender_idle_en = 1'b0;
        hold_req = 800;
        send_request(REQ_CLEAR, 0, 0);
        for (int i = 0; i < 10; i++)
            send_request(REQ_ALLOC, $urandom_range(0, 20), $urandom_range(0, 20));
        sender_idle_en = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_fill_until_full();
        test_output_backpressure();
        test_random_mix();

        i_valid <= 1'b0;
        while (placement_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[skyline_atlas_allocator] OK");
        end else begin
            $display("[skyline_atlas_allocator] ERROR");
        end
        $finish;
    end

endmodule
